@@ src/rms_pkg.sv @@
// ----------------------------------------------------------------------------
// rms_pkg: shared types and constants for the running median smoother
// Cell link record, sequencer states and the reciprocal used for the
// divide by five.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int DATA_W      = 32;
  localparam int WINDOW_DEF  = 9;
  // Wide enough for ages up to 31, so windows of up to 32 entries
  localparam int AGE_W       = 5;
  localparam int PROD_W      = 2 * DATA_W;
  // floor(n/5) == (n * RECIP) >> RECIP_SHIFT for every 32-bit n
  localparam logic [DATA_W-1:0] RECIP = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 34;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [AGE_W-1:0]  age_t;

  // What one cell shows its neighbors
  typedef struct packed {
    data_t val;       // stored value
    age_t  age;       // items since this value was written
    logic  gt;        // stored value > incoming sample
    logic  del_seen;  // the oldest entry sits here or to the left
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

@@ src/rms_in_if.sv @@
// ----------------------------------------------------------------------------
// rms_in_if: sample channel
// Valid/ready channel carrying one raw sample per item.
// ----------------------------------------------------------------------------
interface rms_in_if;
  logic                      valid;
  logic                      ready;
  logic [rms_pkg::DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ src/rms_out_if.sv @@
// ----------------------------------------------------------------------------
// rms_out_if: result channel
// Valid/ready channel carrying one filtered value per item.
// ----------------------------------------------------------------------------
interface rms_out_if;
  logic                      valid;
  logic                      ready;
  logic [rms_pkg::DATA_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink (input valid, input filtered, output ready);
endinterface

@@ src/rms_cell.sv @@
// ----------------------------------------------------------------------------
// rms_cell: one slot of the sorted window
// Holds a value and its age. On each accepted item the oldest value drops
// out of the row and the new sample is inserted in sorted position; each
// cell picks its next value from itself, a neighbor or the sample.
// ----------------------------------------------------------------------------
module rms_cell #(
  parameter int WINDOW   = rms_pkg::WINDOW_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift,
  input  rms_pkg::data_t sample,
  input  rms_pkg::link_t left,
  input  rms_pkg::link_t right,
  output rms_pkg::link_t link
);
  import rms_pkg::*;

  data_t val_r, val_nxt;
  age_t  age_r, age_nxt;
  logic  gt_own;
  logic  del_own;
  logic  before_del;
  logic  below_ok;

  assign gt_own     = val_r > sample;
  assign del_own    = age_r == age_t'(WINDOW - 1);
  assign before_del = !left.del_seen && !del_own;

  assign link.val      = val_r;
  assign link.age      = age_r;
  assign link.gt       = gt_own;
  assign link.del_seen = left.del_seen | del_own;

  // With the oldest entry removed at or left of here, the entry just below
  // this slot is the left neighbor when this cell is the removed one.
  assign below_ok = del_own ? !left.gt : !gt_own;

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r;
    if (before_del) begin
      if (!gt_own) begin
        val_nxt = val_r;
        age_nxt = age_r + age_t'(1);
      end else if (!left.gt) begin
        val_nxt = sample;
        age_nxt = '0;
      end else begin
        val_nxt = left.val;
        age_nxt = left.age + age_t'(1);
      end
    end else begin
      if (!right.gt) begin
        val_nxt = right.val;
        age_nxt = right.age + age_t'(1);
      end else if (below_ok) begin
        val_nxt = sample;
        age_nxt = '0;
      end else if (del_own) begin
        val_nxt = left.val;
        age_nxt = left.age + age_t'(1);
      end else begin
        val_nxt = val_r;
        age_nxt = age_r + age_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= age_t'(CELL_IDX);
    end else if (shift) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule

@@ src/rms_smooth.sv @@
// ----------------------------------------------------------------------------
// rms_smooth: smoothing stage and result register
// Computes floor((4*prev + median)/5) as prev + floor((median - prev)/5),
// with the divide done by a 32x32 reciprocal multiply over a short sequence.
// ----------------------------------------------------------------------------
module rms_smooth (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rms_pkg::data_t  median,
  output logic            idle,
  rms_out_if.source       out_ch
);
  import rms_pkg::*;

  state_t state_r, state_nxt;

  data_t              prev_r;
  data_t              mag_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  data_t              filtered_r;
  logic               out_valid_r;

  logic [DATA_W:0]    diff;
  logic [Q_W-1:0]     quot;
  data_t              result;
  logic               out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  // median - prev as 33-bit two's complement; for a negative difference
  // take |d|-1 (= ~d) so that floor(d/5) = -floor((|d|-1)/5) - 1
  assign diff = {1'b0, median} - {1'b0, prev_r};
  assign quot = prod_r[PROD_W-1:RECIP_SHIFT];
  assign result = neg_r ? (prev_r - DATA_W'(quot) - DATA_W'(1))
                        : (prev_r + DATA_W'(quot));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start)    state_nxt = ST_DIFF;
      ST_DIFF:               state_nxt = ST_MUL;
      ST_MUL:                state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default:               state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: idle = 1'b1;
      default: idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        prev_r      <= result;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIFF) begin
      neg_r <= diff[DATA_W];
      mag_r <= diff[DATA_W] ? ~diff[DATA_W-1:0] : diff[DATA_W-1:0];
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(mag_r) * PROD_W'(RECIP);
    end
    if (state_r == ST_FIN && out_free) begin
      filtered_r <= result;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = filtered_r;

endmodule

@@ src/running_median9_smoother.sv @@
// ----------------------------------------------------------------------------
// running_median9_smoother: running median filter with light smoothing
// Each input item carries one 32-bit unsigned sample on in_ch; each item
// yields exactly one result item on out_ch:
//   filtered = floor((4*previous filtered + median of last WINDOW samples)/5)
// The window is kept sorted in a row of WINDOW cells; the new sample
// replaces the oldest entry as the item is accepted, and the middle cell
// is the median. An accepted item passes through the smoothing states
// (difference, reciprocal multiply, add back); the result is registered
// once the output register is free, and a new item is taken only when the
// sequence is done, since each result feeds the next one.
// in_ch.ready is high only while no item is in flight. If out_ch stalls,
// the result waits in the output register and the block holds the next
// result back until the register frees, so ready stays low meanwhile.
// Reset (rst_n low, synchronous) clears the window and the previous output
// to zero, so the first medians include zeros.
// ----------------------------------------------------------------------------
module running_median9_smoother #(
  parameter int WINDOW = rms_pkg::WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rms_in_if.sink    in_ch,
  rms_out_if.source out_ch
);
  import rms_pkg::*;

  link_t links [WINDOW];
  link_t edge_lo;
  link_t edge_hi;
  logic  accept;
  logic  idle;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = idle;

  // Row ends: nothing below the first cell, "greater" above the last
  assign edge_lo = '{val: '0, age: '0, gt: 1'b0, del_seen: 1'b0};
  assign edge_hi = '{val: '0, age: '0, gt: 1'b1, del_seen: 1'b0};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rms_cell #(
      .WINDOW   (WINDOW),
      .CELL_IDX (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (accept),
      .sample (in_ch.sample),
      .left   ((i == 0) ? edge_lo : links[(i == 0) ? 0 : i - 1]),
      .right  ((i == WINDOW - 1) ? edge_hi : links[(i == WINDOW - 1) ? i : i + 1]),
      .link   (links[i])
    );
  end

  rms_smooth u_smooth (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .median (links[WINDOW / 2].val),
    .idle   (idle),
    .out_ch (out_ch)
  );

endmodule

@@ tb/rms_tracker_pkg.sv @@
// ----------------------------------------------------------------------------
// rms_tracker_pkg: expected-result tracking for the median smoother bench
// Keeps its own sample window and previous output, works out the filtered
// value for every accepted sample and checks results against them in order.
// ----------------------------------------------------------------------------
package rms_tracker_pkg;
  import rms_pkg::*;

  localparam int TAPS = WINDOW_DEF;

  class median_tracker;
    data_t       taps[TAPS];
    int unsigned next_tap;
    data_t       last_filtered;
    data_t       filtered_due[$];
    int          n_errors;
    int          n_samples;
    int          n_results;

    function new();
      foreach (taps[i]) taps[i] = '0;
      next_tap      = 0;
      last_filtered = '0;
      n_errors      = 0;
      n_samples     = 0;
      n_results     = 0;
    endfunction

    // rank TAPS/2 in ascending order; duplicates count once per copy
    function data_t window_median();
      data_t ordered[$];
      foreach (taps[i]) ordered.push_back(taps[i]);
      ordered.sort();
      return ordered[TAPS/2];
    endfunction

    function void note_sample(data_t s);
      data_t             med;
      logic [DATA_W+2:0] acc;
      taps[next_tap] = s;
      next_tap = (next_tap + 1 >= TAPS) ? 0 : next_tap + 1;
      med = window_median();
      // 35-bit sum, no wrap
      acc = ({3'b000, last_filtered} << 2) + {3'b000, med};
      last_filtered = data_t'(acc / 5);
      filtered_due.push_back(last_filtered);
      n_samples++;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      n_errors++;
    endtask

    task check_result(data_t got);
      data_t want;
      n_results++;
      if (filtered_due.size() == 0) begin
        report($sformatf("unexpected result filtered=%h", got));
      end else begin
        want = filtered_due.pop_front();
        if (got !== want)
          report($sformatf("result %0d filtered=%h, want %h", n_results, got, want));
      end
    endtask

    task check_drained();
      if (filtered_due.size() != 0)
        report($sformatf("%0d results never arrived", filtered_due.size()));
    endtask
  endclass

endpackage

@@ tb/running_median9_smoother_test.sv @@
// ----------------------------------------------------------------------------
// running_median9_smoother_test: bench for the running median smoother
// Drives directed and random samples with random gaps on both channels and
// checks every filtered result against an independent window/median model.
// ----------------------------------------------------------------------------
module running_median9_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rms_pkg::*;
  import rms_tracker_pkg::*;

  localparam int MAX_GAP    = 17;
  localparam int STALL_MAX  = 1000;
  localparam int RAND_ITEMS = 950;
  localparam int BLOCK      = 50;

  typedef enum int {
    MIX_FULL,
    MIX_LOW,
    MIX_HIGH,
    MIX_CLUSTER,
    MIX_REPEAT
  } sample_mix_t;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int   stall_cycles = 0;

  rms_in_if  in_ch();
  rms_out_if out_ch();

  median_tracker trk = new();

  running_median9_smoother uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_sample(input data_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    trk.note_sample(s);
  endtask

  // result side back-pressure
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        trk.check_result(out_ch.filtered);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("watchdog: no item moved for %0d cycles", STALL_MAX);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    data_t       directed[$];
    data_t       s;
    data_t       base;
    sample_mix_t mix;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    rst_n        = 1'b0;
    no_idle      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // early samples see the cleared window; then a full window at max
    // drives the large-sum path; equal values and bit patterns follow
    directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0005,
                 32'h0000_0005, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000};
    foreach (directed[i]) send_sample(directed[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % BLOCK == 0) begin
        mix     = sample_mix_t'($urandom_range(MIX_FULL, MIX_REPEAT));
        no_idle = ($urandom_range(0, 3) == 0);
        base    = $urandom;
      end
      case (mix)
        MIX_FULL:    s = $urandom;
        MIX_LOW:     s = $urandom_range(0, 15);
        MIX_HIGH:    s = 32'hFFFF_FFFF - $urandom_range(0, 15);
        MIX_CLUSTER: s = base + $urandom_range(0, 3);
        default:     s = ($urandom_range(0, 7) == 0) ? $urandom : base;
      endcase
      send_sample(s);
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    while (trk.filtered_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    trk.check_drained();

    $display("Ran %0d samples (directed edge values, then random, low, near-max,",
             trk.n_samples);
    $display("clustered and repeated runs) and checked %0d results; %0d mismatches",
             trk.n_results, trk.n_errors);
    if (trk.n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
